// ===== sv/lrd_pkg.sv =====
package lrd_pkg;

   localparam int COORD_W = 6;
   localparam int COLOR_W = 32;
   localparam int DELTA_W = 7;
   localparam int CNT_W   = 7;
   localparam int ERR_W   = 9;
   localparam int INC_W   = 18;
   localparam int ACC_W   = 23;
   localparam int FRAC_W  = 16;

   localparam logic MODE_DDA  = 1'b0;
   localparam logic MODE_BRES = 1'b1;

   // classified line command passed from setup to the walker
   typedef struct packed {
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic [COORD_W-1:0] steps;
      logic [COLOR_W-1:0] color;
      logic mode;
   } cmd_type;

endpackage

// ===== sv/lrd_divider.sv =====
module lrd_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [lrd_pkg::COORD_W-1:0] dividend_mag,
   input  logic [lrd_pkg::COORD_W-1:0] divisor,
   output logic busy,
   output logic [lrd_pkg::INC_W-2:0] quotient
);
   import lrd_pkg::*;

   localparam int QW = INC_W - 1;
   localparam int CW = $clog2(QW + 1);

   // restoring division of (mag << 16) by divisor, one quotient bit per cycle
   logic [QW-1:0] num_ff, num_in;
   logic [COORD_W:0] rem_ff, rem_in;
   logic [COORD_W-1:0] div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [COORD_W+1:0] trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, num_ff[QW-1]} - {2'b00, div_ff};
      if (start) begin
         // mag <= divisor, so the upper dividend bits already sit below the divisor
         rem_in  = {2'b00, dividend_mag[COORD_W-1:1]};
         num_in  = {dividend_mag[0], {FRAC_W{1'b0}}};
         div_in  = divisor;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[COORD_W+1]) begin
            rem_in = trial[COORD_W:0];
            num_in = {num_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[COORD_W-1:0], num_ff[QW-1]};
            num_in = {num_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !$past(busy_ff) || $past(cnt_ff) == CW'(1)) else $error("divider count");
   a_start: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider start");
   a_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider count zero");
endmodule

// ===== sv/lrd_front.sv =====
module lrd_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [lrd_pkg::COORD_W-1:0] req_start_x,
   input  logic [lrd_pkg::COORD_W-1:0] req_start_y,
   input  logic [lrd_pkg::COORD_W-1:0] req_end_x,
   input  logic [lrd_pkg::COORD_W-1:0] req_end_y,
   input  logic [lrd_pkg::COLOR_W-1:0] req_line_color,
   input  logic req_mode,
   output logic q_valid,
   input  logic q_ready,
   output lrd_pkg::cmd_type q_cmd
);
   import lrd_pkg::*;

   // two-entry queue of classified commands
   cmd_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   cmd_type cmd;
   logic [DELTA_W-1:0] adx, ady;
   logic push, pop;

   always_comb begin
      cmd.sx    = req_start_x;
      cmd.sy    = req_start_y;
      cmd.dx    = $signed({1'b0, req_end_x}) - $signed({1'b0, req_start_x});
      cmd.dy    = $signed({1'b0, req_end_y}) - $signed({1'b0, req_start_y});
      adx       = cmd.dx[DELTA_W-1] ? -cmd.dx : cmd.dx;
      ady       = cmd.dy[DELTA_W-1] ? -cmd.dy : cmd.dy;
      cmd.steps = (adx > ady) ? adx[COORD_W-1:0] : ady[COORD_W-1:0];
      cmd.color = req_line_color;
      cmd.mode  = req_mode;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;
   assign q_cmd     = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= cmd;
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff) else $error("queue pointers");
   a_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("queue count");
endmodule

// ===== sv/lrd_back.sv =====
module lrd_back #(
   parameter int TILE_SIZE = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   output logic q_ready,
   input  lrd_pkg::cmd_type q_cmd,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [lrd_pkg::COORD_W-1:0] rsp_pixel_x,
   output logic [lrd_pkg::COORD_W-1:0] rsp_pixel_y,
   output logic [lrd_pkg::COLOR_W-1:0] rsp_pixel_color,
   output logic rsp_pixel_visible,
   output logic rsp_last
);
   import lrd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIVX = 5'b00010,
      ST_DIVY = 5'b00100,
      ST_DDA  = 5'b01000,
      ST_BRES = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   cmd_type cmd_ff;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [ACC_W-1:0] accx_ff, accx_in, accy_ff, accy_in;
   logic signed [INC_W-1:0] incx_ff, incx_in, incy_ff, incy_in;
   logic [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic div_start, div_busy, div_go;
   logic [COORD_W-1:0] div_mag;
   logic [INC_W-2:0] div_q;
   logic [COORD_W-1:0] adx, ady;
   logic signed [ERR_W-1:0] ax2, ay2;
   logic xmajor, emit, out_free;
   logic [COORD_W-1:0] ox, oy;
   logic [ACC_W-1:0] rx, ry;
   logic signed [INC_W-1:0] qs;

   logic ov_ff;
   logic [COORD_W-1:0] ox_ff, oy_ff;
   logic [COLOR_W-1:0] oc_ff;
   logic ovis_ff, olast_ff;

   lrd_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend_mag(div_mag),
      .divisor(cmd_ff.steps), .busy(div_busy), .quotient(div_q)
   );

   assign adx    = cmd_ff.dx[DELTA_W-1] ? COORD_W'(-cmd_ff.dx) : cmd_ff.dx[COORD_W-1:0];
   assign ady    = cmd_ff.dy[DELTA_W-1] ? COORD_W'(-cmd_ff.dy) : cmd_ff.dy[COORD_W-1:0];
   assign ax2    = ERR_W'({adx, 1'b0});
   assign ay2    = ERR_W'({ady, 1'b0});
   assign xmajor = (adx >= ady);
   assign out_free = !ov_ff || rsp_ready;
   assign q_ready  = (state_ff == ST_IDLE);
   assign rx = accx_ff + ACC_W'(32'h8000);
   assign ry = accy_ff + ACC_W'(32'h8000);

   always_comb begin
      state_in = state_ff;
      err_in = err_ff; accx_in = accx_ff; accy_in = accy_ff;
      incx_in = incx_ff; incy_in = incy_ff;
      px_in = px_ff; py_in = py_ff; rem_in = rem_ff;
      div_start = 1'b0; div_go = 1'b0;
      div_mag = adx;
      emit = 1'b0; ox = px_ff; oy = py_ff;
      qs = (cmd_ff.dx[DELTA_W-1]) ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
      case (state_ff)
         ST_IDLE: begin
            // the cmd register loads this cycle; work starts next
         end
         ST_DIVX: begin
            if (!div_busy && !div_go) begin
               div_start = (rem_ff == '0);
               div_mag = adx;
               if (rem_ff != '0) begin
                  incx_in = qs;
                  div_start = 1'b1;
                  div_mag = ady;
                  state_in = ST_DIVY;
               end
               rem_in = CNT_W'(1);
            end
         end
         ST_DIVY: begin
            qs = (cmd_ff.dy[DELTA_W-1]) ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
            if (!div_busy) begin
               incy_in = qs;
               accx_in = ACC_W'({cmd_ff.sx, {FRAC_W{1'b0}}});
               accy_in = ACC_W'({cmd_ff.sy, {FRAC_W{1'b0}}});
               rem_in = CNT_W'(cmd_ff.steps);
               state_in = ST_DDA;
            end
         end
         ST_DDA: begin
            if (out_free) begin
               emit = 1'b1;
               ox = rx[FRAC_W+COORD_W-1:FRAC_W];
               oy = ry[FRAC_W+COORD_W-1:FRAC_W];
               accx_in = accx_ff + ACC_W'(incx_ff);
               accy_in = accy_ff + ACC_W'(incy_ff);
               rem_in = rem_ff - 1'b1;
               if (rem_ff == CNT_W'(1)) state_in = ST_IDLE;
            end
         end
         ST_BRES: begin
            if (out_free) begin
               emit = 1'b1;
               rem_in = rem_ff - 1'b1;
               if (rem_ff == CNT_W'(1)) state_in = ST_IDLE;
               if (xmajor) begin
                  if (err_ff > 0 || (err_ff == 0 && cmd_ff.dx > 0)) begin
                     err_in = err_ff - ax2 + ay2;
                     py_in = py_ff + COORD_W'(cmd_ff.dy[DELTA_W-1] ? -1 : 1);
                  end else err_in = err_ff + ay2;
                  px_in = px_ff + COORD_W'(cmd_ff.dx[DELTA_W-1] ? -1 :
                                           (cmd_ff.dx == 0 ? 0 : 1));
               end else begin
                  if (err_ff > 0 || (err_ff == 0 && cmd_ff.dy > 0)) begin
                     err_in = err_ff - ay2 + ax2;
                     px_in = px_ff + COORD_W'(cmd_ff.dx[DELTA_W-1] ? -1 : 1);
                  end else err_in = err_ff + ax2;
                  py_in = py_ff + COORD_W'(cmd_ff.dy[DELTA_W-1] ? -1 : 1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // idle takes a command and classifies its path
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         if (state_ff == ST_IDLE && q_valid) begin
            if (q_cmd.mode == MODE_BRES) state_ff <= ST_BRES;
            else if (q_cmd.steps != '0) state_ff <= ST_DIVX;
         end else state_ff <= state_in;
         if (emit) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
      end
      if (state_ff == ST_IDLE && q_valid) begin
         cmd_ff <= q_cmd;
         px_ff  <= q_cmd.sx;
         py_ff  <= q_cmd.sy;
         rem_ff <= (q_cmd.mode == MODE_BRES) ? CNT_W'(q_cmd.steps) + 1'b1 : '0;
         // initial error from the major axis, set once per line
         if ((q_cmd.dx[DELTA_W-1] ? -q_cmd.dx : q_cmd.dx) >=
             (q_cmd.dy[DELTA_W-1] ? -q_cmd.dy : q_cmd.dy))
            err_ff <= ERR_W'({(q_cmd.dy[DELTA_W-1] ? -q_cmd.dy : q_cmd.dy), 1'b0})
                    - ERR_W'(q_cmd.steps);
         else
            err_ff <= ERR_W'({(q_cmd.dx[DELTA_W-1] ? -q_cmd.dx : q_cmd.dx), 1'b0})
                    - ERR_W'(q_cmd.steps);
      end else begin
         rem_ff <= rem_in;
         px_ff  <= px_in;
         py_ff  <= py_in;
         err_ff <= err_in;
      end
      accx_ff <= accx_in;
      accy_ff <= accy_in;
      incx_ff <= incx_in;
      incy_ff <= incy_in;
      if (emit) begin
         ox_ff    <= ox;
         oy_ff    <= oy;
         oc_ff    <= cmd_ff.color;
         ovis_ff  <= (ox != '0) && (oy != '0) && (32'(ox) < TILE_SIZE) && (32'(oy) < TILE_SIZE);
         olast_ff <= (rem_ff == CNT_W'(1));
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_pixel_x       = ox_ff;
   assign rsp_pixel_y       = oy_ff;
   assign rsp_pixel_color   = oc_ff;
   assign rsp_pixel_visible = ovis_ff;
   assign rsp_last          = olast_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free) else $error("overwrote pending pixel");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      emit && rem_ff == CNT_W'(1) |=> state_ff == ST_IDLE) else $error("line end");
endmodule

// ===== sv/line_rasterizer_dda_bresenham.sv =====
// line rasterizer for one 64x64 tile
// req channel: one line command per beat (endpoints, color, mode 0 dda / 1 bresenham)
// rsp channel: one pixel per beat, in drawing order, last marks the final pixel
// a two-entry command queue decouples the request side from the pixel walker
// bresenham emits max(|dx|,|dy|)+1 pixels after idle loads the command, and dda first
// runs a bit-serial divider twice, for x then y, to get the q1.16 increments, then
// emits max(|dx|,|dy|) pixels; both emit one per cycle while no pixel waits on rsp_ready
// a zero-length dda line produces no pixel and leaves the walker idle
// pixels beyond row/column 0 and inside the tile are flagged visible
// when rsp_ready is low and a pixel is waiting the walker holds in place; nothing is lost
// reset empties the queue and returns the walker to idle
module line_rasterizer_dda_bresenham #(
   parameter int TILE_SIZE = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [5:0] req_start_x,
   input  logic [5:0] req_start_y,
   input  logic [5:0] req_end_x,
   input  logic [5:0] req_end_y,
   input  logic [31:0] req_line_color,
   input  logic req_mode,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [5:0] rsp_pixel_x,
   output logic [5:0] rsp_pixel_y,
   output logic [31:0] rsp_pixel_color,
   output logic rsp_pixel_visible,
   output logic rsp_last
);
   import lrd_pkg::*;

   logic q_valid, q_ready;
   cmd_type q_cmd;

   lrd_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_start_x(req_start_x), .req_start_y(req_start_y), .req_end_x(req_end_x),
      .req_end_y(req_end_y), .req_line_color(req_line_color), .req_mode(req_mode),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   lrd_back #(.TILE_SIZE(TILE_SIZE)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y), .rsp_pixel_color(rsp_pixel_color),
      .rsp_pixel_visible(rsp_pixel_visible), .rsp_last(rsp_last)
   );
endmodule

// ===== sim/line_pixel_checker.sv =====
`timescale 1ns / 100ps
module line_pixel_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic [5:0] req_start_x,
   input  logic [5:0] req_start_y,
   input  logic [5:0] req_end_x,
   input  logic [5:0] req_end_y,
   input  logic [31:0] req_line_color,
   input  logic req_mode,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [5:0] rsp_pixel_x,
   input  logic [5:0] rsp_pixel_y,
   input  logic [31:0] rsp_pixel_color,
   input  logic rsp_pixel_visible,
   input  logic rsp_last,
   output int   fail_count,
   output int   pixels_pending
);
   import lrd_pkg::*;

   typedef struct {
      logic [5:0]  x;
      logic [5:0]  y;
      logic [31:0] color;
      logic        visible;
      logic        last;
   } pixel_type;

   pixel_type expected_pixels[$];

   function automatic int q16_step(int d, int steps);
      int mag;
      int q;
      mag = (d < 0) ? -d : d;
      q = (mag * 65536) / steps;
      return (d < 0) ? -q : q;
   endfunction

   task automatic push_pixel(int x, int y, logic [31:0] color, bit fin);
      pixel_type p;
      p.x = x[5:0];
      p.y = y[5:0];
      p.color = color;
      p.visible = (p.x != 0) && (p.y != 0);
      p.last = fin;
      expected_pixels.push_back(p);
   endtask

   task automatic rasterize(int sx, int sy, int ex, int ey, logic [31:0] color, logic mode);
      int dx, dy, adx, ady, steps, left, ix, iy, ax2, ay2, err, px, py;
      int acc_x, acc_y, inc_x, inc_y;
      dx = ex - sx;
      dy = ey - sy;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      steps = (adx > ady) ? adx : ady;
      if (mode == MODE_DDA) begin
         if (steps > 0) begin
            inc_x = q16_step(dx, steps);
            inc_y = q16_step(dy, steps);
            acc_x = sx * 65536;
            acc_y = sy * 65536;
            for (left = steps; left > 0; left--) begin
               push_pixel((acc_x + 32768) >>> 16, (acc_y + 32768) >>> 16, color, left == 1);
               acc_x += inc_x;
               acc_y += inc_y;
            end
         end
      end else begin
         ix = (dx > 0) - (dx < 0);
         iy = (dy > 0) - (dy < 0);
         ax2 = adx * 2;
         ay2 = ady * 2;
         px = sx;
         py = sy;
         left = steps;
         push_pixel(px, py, color, left == 0);
         if (ax2 >= ay2) begin
            err = ay2 - (ax2 >>> 1);
            while (left > 0) begin
               if (err > 0 || (err == 0 && ix > 0)) begin
                  err -= ax2;
                  py += iy;
               end
               err += ay2;
               px += ix;
               left--;
               push_pixel(px, py, color, left == 0);
            end
         end else begin
            err = ax2 - (ay2 >>> 1);
            while (left > 0) begin
               if (err > 0 || (err == 0 && iy > 0)) begin
                  err -= ay2;
                  px += ix;
               end
               err += ax2;
               py += iy;
               left--;
               push_pixel(px, py, color, left == 0);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         fail_count <= 0;
         pixels_pending <= 0;
      end else begin
         if (req_valid && req_ready)
            rasterize(req_start_x, req_start_y, req_end_x, req_end_y, req_line_color, req_mode);
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel beat x=%0d y=%0d", rsp_pixel_x, rsp_pixel_y);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_x !== want.x || rsp_pixel_y !== want.y
                   || rsp_pixel_color !== want.color || rsp_pixel_visible !== want.visible
                   || rsp_last !== want.last)
                  fail_count <= fail_count + 1;
               if (rsp_pixel_x !== want.x)
                  $error("pixel_x expected %0d actual %0d", want.x, rsp_pixel_x);
               if (rsp_pixel_y !== want.y)
                  $error("pixel_y expected %0d actual %0d", want.y, rsp_pixel_y);
               if (rsp_pixel_color !== want.color)
                  $error("pixel_color expected %h actual %h", want.color, rsp_pixel_color);
               if (rsp_pixel_visible !== want.visible)
                  $error("pixel_visible expected %0b actual %0b", want.visible,
                         rsp_pixel_visible);
               if (rsp_last !== want.last)
                  $error("last expected %0b actual %0b", want.last, rsp_last);
            end
         end
         pixels_pending <= expected_pixels.size();
      end
   end

endmodule

// ===== sim/tb_line_rasterizer_dda_bresenham.sv =====
`timescale 1ns / 100ps
module tb_line_rasterizer_dda_bresenham;
   import lrd_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [5:0] req_start_x = 0, req_start_y = 0, req_end_x = 0, req_end_y = 0;
   logic [31:0] req_line_color = 0;
   logic req_mode = MODE_DDA;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [5:0] rsp_pixel_x, rsp_pixel_y;
   logic [31:0] rsp_pixel_color;
   logic rsp_pixel_visible, rsp_last;
   int fail_count, pixels_pending;

   line_rasterizer_dda_bresenham i_dut (.*);
   line_pixel_checker i_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("line_rasterizer_dda_bresenham regression: fail");
      $finish;
   end

   // receiver: random stall before each pixel beat, sometimes none at all
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (gap != 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_line(int sx, int sy, int ex, int ey, logic [31:0] color, logic mode);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_start_x <= sx[5:0];
      req_start_y <= sy[5:0];
      req_end_x <= ex[5:0];
      req_end_y <= ey[5:0];
      req_line_color <= color;
      req_mode <= mode;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      int m, len, sx, sy;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (m = 0; m < 2; m++) begin
         send_line(0, 0, 63, 63, 32'h0000_0000, m);
         send_line(63, 63, 0, 0, 32'hffff_ffff, m);
         send_line(0, 63, 63, 0, 32'haaaa_5555, m);
         send_line(5, 5, 5, 5, 32'h5555_aaaa, m);
         send_line(10, 0, 40, 0, 32'h1234_5678, m);
         send_line(0, 10, 0, 50, 32'h8765_4321, m);
         send_line(10, 10, 20, 15, 32'hdead_beef, m);   // x-major tie
         send_line(20, 15, 10, 10, 32'hcafe_f00d, m);
         send_line(10, 10, 15, 20, 32'h0bad_cafe, m);   // y-major tie
         send_line(15, 20, 10, 10, 32'hfeed_face, m);
         send_line(1, 2, 62, 3, $urandom, m);
      end
      repeat (220) begin
         // mostly short lines, a few long ones
         len = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 12);
         sx = $urandom_range(0, 63);
         sy = $urandom_range(0, 63);
         if ($urandom_range(0, 5) == 0)
            send_line(sx, sy, $urandom_range(0, 63), $urandom_range(0, 63), $urandom,
                      $urandom_range(0, 1));
         else
            send_line(sx, sy,
                      $urandom_range((sx > len) ? sx - len : 0, (sx + len > 63) ? 63 : sx + len),
                      $urandom_range((sy > len) ? sy - len : 0, (sy + len > 63) ? 63 : sy + len),
                      $urandom, $urandom_range(0, 1));
      end
      req_valid <= 0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("line_rasterizer_dda_bresenham regression: pass");
      else
         $display("line_rasterizer_dda_bresenham regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
sv/lrd_pkg.sv
sv/lrd_divider.sv
sv/lrd_front.sv
sv/lrd_back.sv
sv/line_rasterizer_dda_bresenham.sv
sim/line_pixel_checker.sv
sim/tb_line_rasterizer_dda_bresenham.sv
